FILE: hw/rtl/stereo_envelope_maximizer_core_assert.svh
// assertion macros for the stereo envelope maximizer
// expects clk and rst in the scope where the macros are used
`ifndef STEREO_ENVELOPE_MAXIMIZER_CORE_ASSERT_SVH
`define STEREO_ENVELOPE_MAXIMIZER_CORE_ASSERT_SVH
`ifndef SYNTH
`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SEM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEM_ASSERT(lbl, prop, msg)
`define SEM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/sem_pkg.sv
// shared types, constants and helpers for the stereo envelope maximizer
// no dependencies
package sem_pkg;

  localparam int DELAY_DEPTH = 16;
  localparam int PTR_W = $clog2(DELAY_DEPTH);
  localparam int ADDR_W = 3;

  localparam logic [23:0] FULL_SCALE = 24'h7FFFFF;
  localparam logic [22:0] KNEE_RESET = 23'h7FFFFF;
  localparam logic [4:0] DECAY_RESET = 5'd10;
  localparam logic [4:0] DECAY_MIN = 5'd5;
  localparam logic [4:0] DECAY_MAX = 5'd30;
  localparam logic [4:0] STEPS_DECAY = 5'd25;
  localparam logic [4:0] STEPS_GAIN = 5'd23;

  localparam logic REG_KNEE = 1'b0;
  localparam logic REG_DECAY = 1'b1;

  typedef struct packed {
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
  } sem_in_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } sem_out_t;

  typedef struct packed {
    logic [22:0] knee;
    logic [4:0] decay;
    logic [3:0] delay;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic [23:0] rem;
    logic [24:0] dvd;
    logic [23:0] dvs;
    logic [4:0] steps;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [24:0] quot;
  } div_rsp_t;

  function automatic logic [23:0] mag24(input logic [23:0] s);
    mag24 = s[23] ? (~s + 24'd1) : s;
  endfunction

  function automatic logic [23:0] signed_out(input logic [23:0] m, input logic neg);
    signed_out = neg ? (~m + 24'd1) : m;
  endfunction

endpackage

FILE: hw/rtl/stereo_envelope_maximizer_core.sv
// stereo envelope maximizer top level: control sequencer, envelope, output word
// depends on sem_pkg, sem_regs, sem_dline, sem_div and the assertion header
//
// usage
// - sample channel (valid/ready) takes one stereo word of signed q1.23 samples
// - result channel (valid/ready) gives one word per sample: the delayed pair
//   divided by max(envelope, knee), saturated to 24-bit full scale
// - apb-style port: knee level at byte 0, decay samples at byte 4; write only
//   while the block is idle
// - one word at a time: after acceptance the 25-step envelope division runs
//   when the envelope decays, then the 23-step gain division (both channels
//   in parallel) in sem_div; the result word is formed once both are done
// - sample_ready is high only while the sequencer is idle; a finished result
//   waits in the output register, and the next sample is taken meanwhile
// - a stalled receiver holds the result; the block then waits after its
//   divisions until the previous word has gone
// - reset clears envelope, write position and delay contents (through valid
//   bits, no clearing pass) and restores knee and decay
`include "stereo_envelope_maximizer_core_assert.svh"

module stereo_envelope_maximizer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  sem_pkg::sem_in_t           sample,
  output logic                       result_valid,
  input  logic                       result_ready,
  output sem_pkg::sem_out_t          result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sem_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENV   = 3'd1;
  localparam logic [2:0] S_DECAY = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  sem_pkg::cfg_t     cfg;
  sem_pkg::div_req_t req_l;
  sem_pkg::div_req_t req_r;
  sem_pkg::div_rsp_t rsp_l;
  sem_pkg::div_rsp_t rsp_r;

  logic [2:0]                state;
  logic [sem_pkg::PTR_W-1:0] wpos;
  logic [sem_pkg::PTR_W-1:0] wpos_next;
  logic [sem_pkg::PTR_W-1:0] rpos;
  logic [23:0]               env;
  logic [23:0]               level;
  logic [23:0]               dl;
  logic [23:0]               dr;
  logic                      sat_l;
  logic                      sat_r;
  logic [47:0]               rdata;
  logic                      accept;
  logic                      load_out;
  logic [23:0]               mag_l;
  logic [23:0]               mag_r;
  logic [23:0]               mag_in_l;
  logic [23:0]               mag_in_r;
  logic [23:0]               den;
  logic [23:0]               env_diff;
  logic [23:0]               out_mag_l;
  logic [23:0]               out_mag_r;

  sem_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  sem_dline u_dline (
    .clk(clk), .rst(rst), .we(accept), .waddr(wpos),
    .wdata({sample.left_in, sample.right_in}), .raddr(rpos), .rdata(rdata)
  );

  sem_div u_div_l (.clk(clk), .rst(rst), .req(req_l), .rsp(rsp_l));
  sem_div u_div_r (.clk(clk), .rst(rst), .req(req_r), .rsp(rsp_r));

  assign sample_ready = (state == S_IDLE);
  assign accept = sample_valid && sample_ready;
  assign load_out = !result_valid || result_ready;

  always_comb begin
    if (wpos == sem_pkg::PTR_W'(sem_pkg::DELAY_DEPTH - 1)) begin
      wpos_next = '0;
    end else begin
      wpos_next = wpos + sem_pkg::PTR_W'(1);
    end
    if (wpos >= sem_pkg::PTR_W'(cfg.delay)) begin
      rpos = wpos - sem_pkg::PTR_W'(cfg.delay);
    end else begin
      rpos = wpos + sem_pkg::PTR_W'(sem_pkg::DELAY_DEPTH) - sem_pkg::PTR_W'(cfg.delay);
    end
  end

  always_comb begin
    mag_in_l = sem_pkg::mag24(sample.left_in);
    mag_in_r = sem_pkg::mag24(sample.right_in);
    mag_l = sem_pkg::mag24(dl);
    mag_r = sem_pkg::mag24(dr);
    den = (env > {1'b0, cfg.knee}) ? env : {1'b0, cfg.knee};
    env_diff = env - level;
    out_mag_l = sat_l ? sem_pkg::FULL_SCALE : {1'b0, rsp_l.quot[22:0]};
    out_mag_r = sat_r ? sem_pkg::FULL_SCALE : {1'b0, rsp_r.quot[22:0]};
  end

  always_comb begin
    req_l = '0;
    req_r = '0;
    if (state == S_ENV && level <= env) begin
      req_l.start = 1'b1;
      req_l.rem = '0;
      req_l.dvd = {1'b0, env_diff} + {21'd0, cfg.decay[4:1]};
      req_l.dvs = {19'd0, cfg.decay};
      req_l.steps = sem_pkg::STEPS_DECAY;
    end else if (state == S_START) begin
      req_l.start = 1'b1;
      req_l.rem = (mag_l >= den) ? 24'd0 : mag_l;
      req_l.dvd = '0;
      req_l.dvs = den;
      req_l.steps = sem_pkg::STEPS_GAIN;
      req_r.start = 1'b1;
      req_r.rem = (mag_r >= den) ? 24'd0 : mag_r;
      req_r.dvd = '0;
      req_r.dvs = den;
      req_r.steps = sem_pkg::STEPS_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wpos <= '0;
      env <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            wpos <= wpos_next;
            state <= S_ENV;
          end
        end
        S_ENV: begin
          if (level > env) begin
            env <= level;
            state <= S_START;
          end else begin
            state <= S_DECAY;
          end
        end
        S_DECAY: begin
          if (rsp_l.done) begin
            env <= env - rsp_l.quot[23:0];
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (rsp_l.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      level <= (mag_in_l > mag_in_r) ? mag_in_l : mag_in_r;
    end
    if (state == S_ENV) begin
      dl <= rdata[47:24];
      dr <= rdata[23:0];
    end
    if (state == S_START) begin
      sat_l <= (mag_l >= den);
      sat_r <= (mag_r >= den);
    end
    if (state == S_OUT && load_out) begin
      result.left_out <= sem_pkg::signed_out(out_mag_l, dl[23]);
      result.right_out <= sem_pkg::signed_out(out_mag_r, dr[23]);
    end
  end

  `SEM_ASSERT(a_busy_after_accept, accept |=> !sample_ready, "sample taken while busy")
  `SEM_ASSERT(a_env_floor, (state == S_START) |-> (env >= level), "envelope below level")
  `SEM_ASSERT(a_wpos_hold, !accept |=> $stable(wpos), "write position moved without a word")
  `SEM_ASSERT(a_no_neg_full, result_valid |-> (result.left_out != 24'sh800000 && result.right_out != 24'sh800000), "result beyond full scale")
  `SEM_ASSERT_RST(a_reset_idle, rst |=> (state == S_IDLE && !result_valid), "not idle after reset")

endmodule

FILE: hw/rtl/sem_div.sv
// restoring divider, one quotient bit per cycle
// depends on sem_pkg
module sem_div (
  input  logic              clk,
  input  logic              rst,
  input  sem_pkg::div_req_t req,
  output sem_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [23:0] rem;
  logic [24:0] quot;
  logic [23:0] dvs;

  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;
  logic [23:0] rem_next;
  logic [24:0] quot_next;

  always_comb begin
    trial = {rem, quot[24]};
    diff = trial - {1'b0, dvs};
    ge = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[23:0] : trial[23:0];
    quot_next = {quot[23:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 5'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem;
      quot <= req.dvd;
      dvs <= req.dvs;
    end else if (busy) begin
      rem <= rem_next;
      quot <= quot_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

FILE: hw/rtl/sem_dline.sv
// stereo delay line memory, one write and one registered read per cycle
// depends on sem_pkg; entries never written read as zero
module sem_dline (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [sem_pkg::PTR_W-1:0] waddr,
  input  logic [47:0]               wdata,
  input  logic [sem_pkg::PTR_W-1:0] raddr,
  output logic [47:0]               rdata
);

  logic [47:0] mem [sem_pkg::DELAY_DEPTH];
  logic [sem_pkg::DELAY_DEPTH-1:0] valid;
  logic [47:0] rword;
  logic        rvalid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rword <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvalid ? rword : '0;

endmodule

FILE: hw/rtl/sem_regs.sv
// configuration registers behind the apb-style port
// depends on sem_pkg; gives knee and decay with their limits applied
module sem_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sem_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output sem_pkg::cfg_t              cfg
);

  logic [22:0] knee_level;
  logic [4:0]  decay_samples;
  logic        wr;
  logic [4:0]  decay_eff;
  logic [5:0]  decay_inc;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      knee_level <= sem_pkg::KNEE_RESET;
      decay_samples <= sem_pkg::DECAY_RESET;
    end else if (wr) begin
      if (paddr[2] == sem_pkg::REG_KNEE) begin
        knee_level <= pwdata[22:0];
      end else begin
        decay_samples <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      sem_pkg::REG_KNEE:  prdata = {9'd0, knee_level};
      sem_pkg::REG_DECAY: prdata = {27'd0, decay_samples};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    if (decay_samples < sem_pkg::DECAY_MIN) begin
      decay_eff = sem_pkg::DECAY_MIN;
    end else if (decay_samples > sem_pkg::DECAY_MAX) begin
      decay_eff = sem_pkg::DECAY_MAX;
    end else begin
      decay_eff = decay_samples;
    end
    decay_inc = {1'b0, decay_eff} + 6'd1;
    cfg.decay = decay_eff;
    cfg.delay = decay_inc[4:1];
    cfg.knee = (knee_level == 23'd0) ? 23'd1 : knee_level;
  end

endmodule

FILE: bench/tb_stereo_envelope_maximizer_core.sv
// self-checking bench for the stereo envelope maximizer core: directed table, then random phases
// predicts result words by its limiter model, typed rows aside; needs sem_pkg and core rtl only
module tb_stereo_envelope_maximizer_core;

  localparam int PHASES = 7;
  localparam int WORDS_PER_PHASE = 64;
  localparam int HOLD_OFF = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL = 60;

  typedef enum logic [1:0] {ROW_WORD, ROW_KNEE, ROW_DECAY} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [23:0] arg_a;
    logic [23:0] arg_b;
    logic        typed;
    logic [23:0] exp_l;
    logic [23:0] exp_r;
  } plan_row_t;

  localparam int PLAN_LEN = 31;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_WORD,  24'h7FFFFF, 24'h800000, 1'b1, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h800000, 24'h7FFFFF, 1'b1, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b1, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'hFFFFFF, 24'h000001, 1'b1, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'h000000, 24'h000000},
    // delayed full-scale words saturate against the reset knee
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b1, 24'h7FFFFF, 24'h800001},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b1, 24'h800001, 24'h7FFFFF},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b1, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b1, 24'hFFFFFF, 24'h000001},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b1, 24'h7FFFFF, 24'h7FFFFF},
    '{ROW_WORD,  24'h01E240, 24'hF6040F, 1'b0, 24'h000000, 24'h000000},
    // zero knee behaves as the smallest knee
    '{ROW_KNEE,  24'h000000, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000001, 24'hFFFFFF, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000100, 24'hFFFF00, 1'b0, 24'h000000, 24'h000000},
    // decay below and above its range
    '{ROW_DECAY, 24'h000003, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h400000, 24'hC00000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000010, 24'h000008, 1'b0, 24'h000000, 24'h000000},
    '{ROW_DECAY, 24'h00001F, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h7FFFFF, 24'h000001, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h012345, 24'h7EDCBA, 1'b0, 24'h000000, 24'h000000},
    '{ROW_KNEE,  24'h000001, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_DECAY, 24'h000005, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000001, 24'h800000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h3FFFFF, 24'hC00001, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h000000, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_DECAY, 24'h00001E, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_KNEE,  24'h7FFFFF, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h800000, 24'h800000, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'h2AAAAA, 24'h555555, 1'b0, 24'h000000, 24'h000000},
    '{ROW_WORD,  24'hAAAAAA, 24'h000000, 1'b0, 24'h000000, 24'h000000}
  };

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  sem_pkg::sem_in_t           sample = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b1;
  sem_pkg::sem_out_t          result;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [sem_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  // limiter model state
  logic [22:0]         knee_q = sem_pkg::KNEE_RESET;
  logic [4:0]          decay_q = sem_pkg::DECAY_RESET;
  logic [23:0]         hist_l [sem_pkg::DELAY_DEPTH];
  logic [23:0]         hist_r [sem_pkg::DELAY_DEPTH];
  int unsigned         wr_ptr = 0;
  int unsigned         env_level = 0;

  sem_pkg::sem_out_t   due_pairs [$];
  sem_pkg::sem_out_t   want_pair;
  int                  mismatches = 0;
  bit                  calm = 1'b0;
  bit                  hold_off_due = 1'b0;
  int                  quiet;

  stereo_envelope_maximizer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < sem_pkg::DELAY_DEPTH; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
  end

  function automatic logic [23:0] gain_scale(input logic [23:0] s, input int unsigned den);
    longint unsigned m;
    logic [23:0] q;
    q = s[23] ? -s : s;
    m = q;
    m = (m << 23) / den;
    if (m > sem_pkg::FULL_SCALE) m = sem_pkg::FULL_SCALE;
    q = m[23:0];
    return s[23] ? -q : q;
  endfunction

  function automatic sem_pkg::sem_out_t limit_pair(input sem_pkg::sem_in_t w);
    logic [23:0] lm, rm;
    int unsigned lvl, d, dly, knee, den, diff, rd;
    sem_pkg::sem_out_t o;
    lm = w.left_in[23] ? -w.left_in : w.left_in;
    rm = w.right_in[23] ? -w.right_in : w.right_in;
    lvl = (lm > rm) ? lm : rm;
    d = decay_q;
    if (d < sem_pkg::DECAY_MIN) d = sem_pkg::DECAY_MIN;
    if (d > sem_pkg::DECAY_MAX) d = sem_pkg::DECAY_MAX;
    dly = (d + 1) / 2;
    knee = (knee_q == '0) ? 1 : knee_q;
    if (lvl > env_level) begin
      env_level = lvl;
    end else begin
      diff = env_level - lvl;
      env_level = env_level - (diff + d / 2) / d;
    end
    den = (env_level > knee) ? env_level : knee;
    hist_l[wr_ptr] = w.left_in;
    hist_r[wr_ptr] = w.right_in;
    rd = (wr_ptr + sem_pkg::DELAY_DEPTH - dly % sem_pkg::DELAY_DEPTH) % sem_pkg::DELAY_DEPTH;
    o.left_out = gain_scale(hist_l[rd], den);
    o.right_out = gain_scale(hist_r[rd], den);
    wr_ptr = (wr_ptr + 1) % sem_pkg::DELAY_DEPTH;
    return o;
  endfunction

  function automatic logic [23:0] rand_sample();
    logic [23:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = 24'($urandom);
      2: v = ($urandom_range(0, 1) == 1) ? 24'h800000 : 24'h7FFFFF;
      3: v = 24'h000000;
      default: begin
        v = 24'($urandom) >> $urandom_range(1, 23);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic sem_pkg::sem_in_t rand_pair();
    logic [23:0] a, b;
    a = rand_sample();
    case ($urandom_range(0, 3))
      0: b = a;
      1: b = -a;
      default: b = rand_sample();
    endcase
    return sem_pkg::sem_in_t'({a, b});
  endfunction

  task automatic send_word(input sem_pkg::sem_in_t w, input logic typed,
                           input sem_pkg::sem_out_t fixed_pair);
    sem_pkg::sem_out_t guess;
    sample <= w;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    guess = limit_pair(w);
    due_pairs.push_back(typed ? fixed_pair : guess);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 2) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (due_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [23:0] value);
    logic [31:0] word;
    word = $urandom;
    if (idx == sem_pkg::REG_KNEE) word[22:0] = value[22:0];
    else word[4:0] = value[4:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == sem_pkg::REG_KNEE) knee_q = word[22:0];
    else decay_q = word[4:0];
  endtask

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (due_pairs.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want_pair = due_pairs.pop_front();
        check_field("left_out", want_pair.left_out, result.left_out);
        check_field("right_out", want_pair.right_out, result.right_out);
      end
    end
  end

  // receiver: ready stretches, short stalls, and one long hold-off
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_stereo_envelope_maximizer_core: errors");
    $finish;
  end

  initial begin
    logic [22:0] knee_val;
    logic [4:0] decay_val;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++) begin
      case (PLAN[k].kind)
        ROW_WORD: begin
          send_word(sem_pkg::sem_in_t'({PLAN[k].arg_a, PLAN[k].arg_b}), PLAN[k].typed,
                    sem_pkg::sem_out_t'({PLAN[k].exp_l, PLAN[k].exp_r}));
          sender_gap();
        end
        ROW_KNEE: begin
          wait_drained();
          reg_write(sem_pkg::REG_KNEE, PLAN[k].arg_a);
        end
        default: begin
          wait_drained();
          reg_write(sem_pkg::REG_DECAY, PLAN[k].arg_a);
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          knee_val = sem_pkg::KNEE_RESET;
          decay_val = sem_pkg::DECAY_MAX;
        end
        1: begin
          knee_val = 23'd1;
          decay_val = sem_pkg::DECAY_MIN;
        end
        3: begin
          knee_val = '0;
          decay_val = 5'd31;
        end
        default: begin
          knee_val = 23'($urandom) >> $urandom_range(0, 22);
          decay_val = 5'($urandom_range(0, 31));
        end
      endcase
      if (ph % 2 == 0) begin
        reg_write(sem_pkg::REG_KNEE, 24'(knee_val));
        reg_write(sem_pkg::REG_DECAY, 24'(decay_val));
      end else begin
        reg_write(sem_pkg::REG_DECAY, 24'(decay_val));
        reg_write(sem_pkg::REG_KNEE, 24'(knee_val));
      end
      if (ph == 2) hold_off_due = 1'b1;
      calm = (ph == PHASES - 1);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(rand_pair(), 1'b0, '0);
        sender_gap();
      end
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_stereo_envelope_maximizer_core: clean");
    end else begin
      $display("tb_stereo_envelope_maximizer_core: errors");
    end
    $finish;
  end

endmodule
